// File: rtl/wcpd_pkg.sv
// Shared constants and types for the wall clock phase discipline block.
// Depends on nothing; used by rtl/wall_clock_phase_discipline.sv.
`default_nettype none

package wcpd_pkg;

	// Code that says where a wall time reading came from.
	typedef logic [1:0] src_t;

	localparam src_t SRC_EXTRAP   = 2'd0;
	localparam src_t SRC_RTC      = 2'd1;
	localparam src_t SRC_FIRMWARE = 2'd2;
	localparam src_t SRC_NONE     = 2'd3;

	// Register indexes on the configuration port (byte address is 8 times the index).
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_PROBE_INTERVAL = 2'd0;
	localparam reg_idx_t REG_FW_TIME        = 2'd1;
	localparam reg_idx_t REG_FW_LATCH       = 2'd2;
	localparam reg_idx_t REG_UNUSED         = 2'd3;

	// Probe interval after reset, a quarter of a second.
	localparam logic [31:0] PROBE_RESET_NS = 32'd250000000;

	// Saturation value of the fixup counter.
	localparam logic [31:0] FIXUP_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/wall_clock_phase_discipline.sv
// Wall clock phase discipline: turns monotonic and coarse RTC readings into wall time.
// Depends on rtl/wcpd_pkg.sv for source codes, register indexes and reset values.
//
// Usage: each item on the input channel (in_valid/in_ready, mono_ns, rtc_ns) is one
// read request and produces exactly one result item on the output channel
// (out_valid/out_ready, wall_ns, source, phase_improved, fixup_total).
// An accepted item sits in an input register, where a single pass of
// logic (a few 64-bit adds and compares side by side, then a selection) works out the
// answer and the new discipline state; the result register and the state are loaded
// at the same edge. An accepted item goes from the input register into the result
// register, from which it is offered. Throughput is one item per cycle while the
// receiver does not stall, set by the update of the base and probe state, which the
// next item reads straight away.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more; in_ready falls only when both are full.
// Reset clears both registers, the base (not established), the last second seen,
// the last probe point and the fixup count, and loads the configuration reset
// values. The APB port writes registers at byte addresses 0, 8 and 16; the user must
// write the port only while no item is in flight; the block does not enforce this.
`default_nettype none

module wall_clock_phase_discipline (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Read request channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] mono_ns,
	input  wire logic [63:0] rtc_ns,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      wall_ns,
	output logic [1:0]       source,
	output logic             phase_improved,
	output logic [31:0]      fixup_total,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	// Configuration registers and the firmware offset kept alongside them.
	logic [31:0] probe_int_q;
	logic [63:0] fw_time_q;
	logic [63:0] fw_latch_q;
	logic [63:0] fw_off_q;

	// Discipline state; the base is held as an offset from the monotonic count.
	logic        base_valid_q;
	logic [63:0] base_off_q;
	logic [63:0] last_sec_q;
	logic [63:0] last_probe_q;
	logic [31:0] fixup_q;

	// Input stage.
	logic        valid_s1;
	logic [63:0] mono_s1;
	logic [63:0] rtc_s1;

	// Result stage.
	logic        valid_s2;
	logic [63:0] wall_s2;
	wcpd_pkg::src_t src_s2;
	logic        improved_s2;
	logic [31:0] fixup_s2;

	logic                advance;
	logic                cfg_wr;
	wcpd_pkg::reg_idx_t  cfg_idx;

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_idx  = wcpd_pkg::reg_idx_t'(paddr[4:3]);

	// Register read back.
	always_comb begin
		unique case (cfg_idx)
			wcpd_pkg::REG_PROBE_INTERVAL: prdata = {32'd0, probe_int_q};
			wcpd_pkg::REG_FW_TIME:        prdata = fw_time_q;
			wcpd_pkg::REG_FW_LATCH:       prdata = fw_latch_q;
			wcpd_pkg::REG_UNUSED:         prdata = 64'd0;
		endcase
	end

	// Configuration writes; the firmware offset follows whichever half changes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_int_q <= wcpd_pkg::PROBE_RESET_NS;
			fw_time_q   <= 64'd0;
			fw_latch_q  <= 64'd0;
			fw_off_q    <= 64'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				wcpd_pkg::REG_PROBE_INTERVAL: probe_int_q <= pwdata[31:0];
				wcpd_pkg::REG_FW_TIME: begin
					fw_time_q <= pwdata;
					fw_off_q  <= pwdata - fw_latch_q;
				end
				wcpd_pkg::REG_FW_LATCH: begin
					fw_latch_q <= pwdata;
					fw_off_q   <= fw_time_q - pwdata;
				end
				wcpd_pkg::REG_UNUSED: ;
			endcase
		end
	end

	// Single pass over the item in the input stage.
	logic [63:0]    extrap;
	logic [63:0]    elapsed;
	logic           probe_early;
	logic           new_second;
	logic           forward_ok;
	logic           set_base;
	logic           take_rtc;
	logic [63:0]    wall_d;
	wcpd_pkg::src_t src_d;
	logic           improved_d;
	logic [31:0]    fixup_d;

	assign extrap      = mono_s1 + base_off_q;
	assign elapsed     = mono_s1 - last_probe_q;
	assign probe_early = base_valid_q && (elapsed < {32'd0, probe_int_q});
	assign new_second  = rtc_s1 != last_sec_q;
	assign forward_ok  = rtc_s1 >= extrap;
	assign take_rtc    = !probe_early && (rtc_s1 != 64'd0);

	always_comb begin
		set_base   = 1'b0;
		improved_d = 1'b0;
		fixup_d    = fixup_q;
		priority if (probe_early) begin
			wall_d = extrap;
			src_d  = wcpd_pkg::SRC_EXTRAP;
		end else if (rtc_s1 != 64'd0) begin
			src_d = wcpd_pkg::SRC_RTC;
			if (!base_valid_q) begin
				set_base = 1'b1;
				wall_d   = rtc_s1;
			end else if (new_second && forward_ok) begin
				set_base   = 1'b1;
				improved_d = 1'b1;
				wall_d     = rtc_s1;
				if (fixup_q != wcpd_pkg::FIXUP_MAX) begin
					fixup_d = fixup_q + 32'd1;
				end
			end else begin
				wall_d = extrap;
			end
		end else if (fw_time_q != 64'd0) begin
			wall_d = mono_s1 + fw_off_q;
			src_d  = wcpd_pkg::SRC_FIRMWARE;
		end else begin
			wall_d = 64'd0;
			src_d  = wcpd_pkg::SRC_NONE;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mono_s1 <= mono_ns;
			rtc_s1  <= rtc_ns;
		end
	end

	// Discipline state, updated as an item that probes the RTC moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= 1'b0;
			base_off_q   <= 64'd0;
			last_sec_q   <= 64'd0;
			last_probe_q <= 64'd0;
			fixup_q      <= 32'd0;
		end else if (valid_s1 && advance && take_rtc) begin
			last_probe_q <= mono_s1;
			last_sec_q   <= rtc_s1;
			fixup_q      <= fixup_d;
			if (set_base) begin
				base_valid_q <= 1'b1;
				base_off_q   <= rtc_s1 - mono_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			wall_s2     <= wall_d;
			src_s2      <= src_d;
			improved_s2 <= improved_d;
			fixup_s2    <= fixup_d;
		end
	end

	assign out_valid      = valid_s2;
	assign wall_ns        = wall_s2;
	assign source         = src_s2;
	assign phase_improved = improved_s2;
	assign fixup_total    = fixup_s2;

	// Once established, the base is never lost.
	a_base_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		base_valid_q |=> base_valid_q)
		else $error("base lost after being established");

	// The fixup count never goes down.
	a_fixup_mono: assert property (@(posedge clk) disable iff (!arst_n)
		fixup_q >= $past(fixup_q))
		else $error("fixup count decreased");

	// A phase improvement is only reported on a read that probed the RTC.
	a_improved_rtc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && phase_improved) |-> (source == wcpd_pkg::SRC_RTC))
		else $error("phase improvement on a read that did not probe");

	// A read without any clock answers zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && source == wcpd_pkg::SRC_NONE) |-> (wall_ns == 64'd0))
		else $error("no clock answer is not zero");

endmodule

`default_nettype wire
